// File: rtl/dng_pkg.sv
// dng_pkg: shared types, status codes and config indexes for the
// depth-normalized gradient core. No dependencies.
`default_nettype none
package dng_pkg;

	localparam int DEPTH_W = 16;
	localparam int DEN_W   = 17;
	localparam int QMAG_W  = 32;
	localparam int CMP_W   = 14;
	localparam int LW_W    = 12;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_BORDER = 2'd1;
	localparam logic [1:0] STAT_ZERO   = 2'd2;

	localparam logic CFG_WEIGHT     = 1'b0;
	localparam logic CFG_LINE_WIDTH = 1'b1;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               frame_start;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] grad_x;
		logic [1:0]         x_status;
		logic signed [31:0] grad_y;
		logic [1:0]         y_status;
	} out_word_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	// sign-apply and saturate a quotient magnitude to signed Q15.16
	function automatic logic [31:0] sat_q16(input logic [QMAG_W-1:0] mag, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (mag[31] && (|mag[30:0])) r = 32'h8000_0000;
			else r = 32'd0 - mag;
		end else begin
			if (mag[31]) r = 32'h7fff_ffff;
			else r = mag;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/dng_line_mem.sv
// dng_line_mem: one-line depth store, one write and one registered read port.
// Depends on dng_pkg.
`default_nettype none
module dng_line_mem #(
	parameter int DEPTH = 2048
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic                              re,
	input  wire logic [$clog2(DEPTH)-1:0]          addr,
	input  wire logic [dng_pkg::DEPTH_W-1:0]       wdata,
	output logic      [dng_pkg::DEPTH_W-1:0]       rdata
);
	import dng_pkg::*;

	logic [DEPTH_W-1:0] mem_q [DEPTH];

	// read-before-write: same-address access returns the old entry
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[addr];
		if (we) mem_q[addr] <= wdata;
	end

endmodule
`default_nettype wire

// File: rtl/dng_div.sv
// dng_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on dng_pkg.
`default_nettype none
module dng_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [dng_pkg::QMAG_W-1:0]    num,
	input  wire logic [dng_pkg::DEN_W-1:0]     den,
	output logic                               done,
	output logic      [dng_pkg::QMAG_W-1:0]    quo
);
	import dng_pkg::*;

	logic [QMAG_W-1:0] num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic [DEN_W:0]    rem_sh;
	logic              fits;

	assign rem_sh = {rem_q, num_q[QMAG_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[QMAG_W-2:0], 1'b0};
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo   <= {quo[QMAG_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

// File: rtl/depth_normalized_gradient_core.sv
// depth_normalized_gradient_core: top level, column/row tracking, line store,
// two dividers and output register. Depends on dng_pkg, dng_line_mem, dng_div.
`default_nettype none
//
//  port group     dir  word           meaning
//  in_*           in   in_word_t      depth pixel + frame_start, raster order
//  out_*          out  out_word_t     grad_x/grad_y Q15.16 with status codes
//  cfg_*          in   16-bit write   0: weight, 1: line_width
//
//  Each pixel passes accept, line-store read, 32 quotient bits from
//  the two bit-serial dividers (run side by side), and the output load.
//  The line store read/write at accept is the only memory access per pixel.
//  Reset sets column, first-row flag, left pixel and weight to 0, line width
//  to 640; the line store is not cleared. A stalled output word holds; the
//  next pixel is accepted while it waits, the result waits for the register.
//
module depth_normalized_gradient_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire dng_pkg::in_word_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output dng_pkg::out_word_t        out_data,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_idx,
	input  wire logic [15:0]          cfg_wdata
);
	import dng_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]         state_q;
	logic [DEPTH_W-1:0] weight_q;
	logic [LW_W-1:0]    lw_q;
	logic [DEPTH_W-1:0] left_q;
	logic [CW-1:0]      col_q;
	logic               past_q;

	// per-pixel working registers
	logic [DEPTH_W-1:0] cur_s1;
	logic [DEPTH_W-1:0] left_s1;
	logic               col0_s1;
	logic               row0_s1;
	logic               negx_s2;
	logic               negy_s2;
	logic               zero_s2;

	logic               acc;
	logic [CW-1:0]      col;
	logic               past;
	logic [CMP_W-1:0]   eff_w;
	logic [CMP_W-1:0]   col_nx;
	logic [DEPTH_W-1:0] above;
	logic [DEN_W-1:0]   den;
	logic signed [DEPTH_W:0] dx;
	logic signed [DEPTH_W:0] dy;
	logic [DEPTH_W-1:0] mx;
	logic [DEPTH_W-1:0] my;
	div_ctl_t           dvx;
	div_ctl_t           dvy;
	logic [QMAG_W-1:0]  qx;
	logic [QMAG_W-1:0]  qy;
	logic               load;

	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign col      = in_data.frame_start ? '0 : col_q;
	assign past     = in_data.frame_start ? 1'b0 : past_q;

	// effective width clamped to [2, MAX_WIDTH]
	always_comb begin
		if (lw_q < LW_W'(2)) eff_w = CMP_W'(2);
		else if (CMP_W'(lw_q) > CMP_W'(MAX_WIDTH)) eff_w = CMP_W'(MAX_WIDTH);
		else eff_w = CMP_W'(lw_q);
	end
	assign col_nx = CMP_W'(col) + CMP_W'(1);

	dng_line_mem #(.DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (acc),
		.re    (acc),
		.addr  (col),
		.wdata (in_data.depth),
		.rdata (above)
	);

	// operands formed in the read cycle
	assign den = DEN_W'(cur_s1) + DEN_W'(weight_q);
	assign dx  = $signed({1'b0, cur_s1}) - $signed({1'b0, left_s1});
	assign dy  = $signed({1'b0, cur_s1}) - $signed({1'b0, above});
	assign mx  = dx[DEPTH_W] ? DEPTH_W'(-dx) : dx[DEPTH_W-1:0];
	assign my  = dy[DEPTH_W] ? DEPTH_W'(-dy) : dy[DEPTH_W-1:0];

	assign dvx.start = (state_q == ST_RD);
	assign dvy.start = (state_q == ST_RD);

	dng_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dvx.start),
		.num    ({mx, 16'd0}),
		.den    (den),
		.done   (dvx.done),
		.quo    (qx)
	);

	dng_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dvy.start),
		.num    ({my, 16'd0}),
		.den    (den),
		.done   (dvy.done),
		.quo    (qy)
	);

	assign load = (state_q == ST_DONE) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			weight_q  <= '0;
			lw_q      <= LW_W'(640);
			left_q    <= '0;
			col_q     <= '0;
			past_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_WEIGHT:     weight_q <= cfg_wdata;
					CFG_LINE_WIDTH: lw_q     <= cfg_wdata[LW_W-1:0];
					default:        ;
				endcase
			end
			if (out_valid && !out_stall && !load) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_RD;
						left_q  <= in_data.depth;
						if (col_nx >= eff_w) begin
							col_q  <= '0;
							past_q <= 1'b1;
						end else begin
							col_q  <= col_nx[CW-1:0];
							past_q <= past;
						end
					end
				end
				ST_RD:   state_q <= ST_DIV;
				ST_DIV:  if (dvx.done) state_q <= ST_DONE;
				ST_DONE: begin
					if (load) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_s1  <= in_data.depth;
			left_s1 <= left_q;
			col0_s1 <= (col == '0);
			row0_s1 <= !past;
		end
		if (state_q == ST_RD) begin
			negx_s2 <= dx[DEPTH_W];
			negy_s2 <= dy[DEPTH_W];
			zero_s2 <= (den == '0);
		end
		if (load) begin
			if (col0_s1) begin
				out_data.grad_x   <= '0;
				out_data.x_status <= STAT_BORDER;
			end else if (zero_s2) begin
				out_data.grad_x   <= '0;
				out_data.x_status <= STAT_ZERO;
			end else begin
				out_data.grad_x   <= sat_q16(qx, negx_s2);
				out_data.x_status <= STAT_OK;
			end
			if (row0_s1) begin
				out_data.grad_y   <= '0;
				out_data.y_status <= STAT_BORDER;
			end else if (zero_s2) begin
				out_data.grad_y   <= '0;
				out_data.y_status <= STAT_ZERO;
			end else begin
				out_data.grad_y   <= sat_q16(qy, negy_s2);
				out_data.y_status <= STAT_OK;
			end
		end
	end

	// both dividers start together and must finish together
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dvx.done == dvy.done) else $error("divider lanes out of step");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == ST_RD) else $error("accept did not start a read");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(col_q) < CMP_W'(MAX_WIDTH)) else $error("column past line store");

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.x_status == STAT_BORDER) |-> out_data.grad_x == 0)
		else $error("border word carries a gradient");

endmodule
`default_nettype wire

// File: sim/depth_normalized_gradient_core_test.sv
// Self-checking bench for depth_normalized_gradient_core: random and directed
// depth streams, predicted gradients compared word by word. Needs dng_pkg.
module depth_normalized_gradient_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dng_pkg::*;

	localparam int MAXW = 2048;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_idx = CFG_WEIGHT;
	logic [15:0] cfg_wdata = '0;

	depth_normalized_gradient_core #(.MAX_WIDTH(MAXW)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state, mirrors the block
	logic [15:0] pr_weight;
	logic [11:0] pr_line_width;
	logic [15:0] pr_left;
	logic [15:0] pr_line [MAXW];
	int unsigned pr_col;
	bit pr_past_row;

	in_word_t pixel_q[$];
	out_word_t gradient_q[$];
	int mismatches = 0;
	int pixels_sent = 0;
	int words_checked = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;	// no random gaps in the final stretch
	int in_gap = 0;
	int out_gap = 0;
	bit accepted_in = 1'b0;

	function automatic logic [31:0] q16_quot(int signed diff, int unsigned den);
		longint signed q;
		q = (longint'(diff) * 65536) / longint'(den);
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	// advance the predictor by one pixel, return the expected word
	function automatic out_word_t predict_gradient(in_word_t px);
		out_word_t r;
		int unsigned w, c, den;
		w = pr_line_width < 2 ? 2 : (pr_line_width > MAXW ? MAXW : pr_line_width);
		if (px.frame_start) begin
			pr_col = 0;
			pr_past_row = 1'b0;
		end
		c = pr_col >= MAXW ? MAXW - 1 : pr_col;
		den = px.depth + pr_weight;
		r = '0;
		if (c == 0) r.x_status = STAT_BORDER;
		else if (den == 0) r.x_status = STAT_ZERO;
		else begin
			r.x_status = STAT_OK;
			r.grad_x = q16_quot(int'(px.depth) - int'(pr_left), den);
		end
		if (!pr_past_row) r.y_status = STAT_BORDER;
		else if (den == 0) r.y_status = STAT_ZERO;
		else begin
			r.y_status = STAT_OK;
			r.grad_y = q16_quot(int'(px.depth) - int'(pr_line[c]), den);
		end
		pr_line[c] = px.depth;
		pr_left = px.depth;
		if (c + 1 >= w) begin
			pr_col = 0;
			pr_past_row = 1'b1;
		end else pr_col = c + 1;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s at word %0d: got %h want %h", what, words_checked, got, want);
		mismatches++;
	endtask

	// driver: present queued pixels with random gaps between words, and random output stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || accepted_in) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					in_data <= pixel_q.pop_front();
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 3);
				end else in_valid <= 1'b0;
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 3);
			end
		end
	end

	// monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		accepted_in = in_valid && !in_stall;
		if (arst_n) begin
			if (accepted_in) begin
				gradient_q.push_back(predict_gradient(in_data));
				pixels_sent++;
			end
			if (out_valid && !out_stall) begin
				if (gradient_q.size() == 0) begin
					report_mismatch("unexpected word", out_data[67:36], '0);
				end else begin
					out_word_t e;
					e = gradient_q.pop_front();
					if (out_data.grad_x !== e.grad_x) report_mismatch("grad_x", out_data.grad_x, e.grad_x);
					if (out_data.x_status !== e.x_status)
						report_mismatch("x_status", 32'(out_data.x_status), 32'(e.x_status));
					if (out_data.grad_y !== e.grad_y) report_mismatch("grad_y", out_data.grad_y, e.grad_y);
					if (out_data.y_status !== e.y_status)
						report_mismatch("y_status", 32'(out_data.y_status), 32'(e.y_status));
				end
				words_checked++;
			end
			// watchdog: cycles without any handshake
			if (accepted_in || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout with %0d words outstanding", gradient_q.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// write one register at a falling edge; block is idle
	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_WEIGHT) pr_weight = val;
		else pr_line_width = val[11:0];
	endtask

	task automatic drain();
		while (pixel_q.size() > 0 || in_valid || gradient_q.size() > 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic void add_pixel(logic [15:0] d, bit fs);
		in_word_t p;
		p.depth = d;
		p.frame_start = fs;
		pixel_q.push_back(p);
	endfunction

	// random frame: mostly smooth depths, some wild values and zeros
	function automatic void add_frame(int unsigned w, int unsigned rows);
		logic [15:0] d;
		d = 16'($urandom);
		for (int unsigned i = 0; i < w * rows; i++) begin
			case ($urandom_range(0, 9))
				0: d = 16'($urandom);
				1: d = 16'd0;
				2: d = 16'hffff;
				default: d = d + 16'($urandom_range(0, 64)) - 16'd32;
			endcase
			add_pixel(d, i == 0 || $urandom_range(0, 150) == 0);
		end
	endfunction

	initial begin
		int unsigned w;
		pr_weight = '0;
		pr_line_width = 12'd640;
		pr_left = '0;
		pr_col = 0;
		pr_past_row = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: zero weight, width 2, extremes and zero denominators
		write_reg(CFG_LINE_WIDTH, 16'd2);
		add_pixel(16'd0, 1'b1);
		add_pixel(16'd0, 1'b0);
		add_pixel(16'hffff, 1'b0);
		add_pixel(16'd0, 1'b0);
		add_pixel(16'd1, 1'b0);
		add_pixel(16'hffff, 1'b0);
		add_pixel(16'd0, 1'b0);
		add_pixel(16'd1, 1'b0);
		add_pixel(16'h8000, 1'b1);
		add_pixel(16'h7fff, 1'b0);
		add_pixel(16'h5555, 1'b0);
		add_pixel(16'haaaa, 1'b0);
		drain();
		// width below range acts as 2, large weight
		write_reg(CFG_LINE_WIDTH, 16'd0);
		write_reg(CFG_WEIGHT, 16'hffff);
		add_pixel(16'd0, 1'b1);
		add_pixel(16'hffff, 1'b0);
		add_pixel(16'hffff, 1'b0);
		add_pixel(16'd0, 1'b0);
		drain();
		// shrink width mid-row: column beyond new width wraps
		write_reg(CFG_WEIGHT, 16'd1);
		write_reg(CFG_LINE_WIDTH, 16'd5);
		for (int i = 0; i < 9; i++) add_pixel(16'(i * 7000), i == 0);
		drain();
		write_reg(CFG_LINE_WIDTH, 16'd3);
		add_pixel(16'd100, 1'b0);
		add_pixel(16'd50, 1'b0);
		drain();

		// random part: several settings, mostly small widths
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: w = 2;
				1: w = 4095;	// acts as the maximum width
				default: w = $urandom_range(2, 24);
			endcase
			write_reg(CFG_LINE_WIDTH, 16'(w));
			write_reg(CFG_WEIGHT, ph == 3 ? 16'hffff : (ph == 2 ? 16'd0 : 16'($urandom_range(0, 300))));
			if (w > MAXW) begin
				for (int i = 0; i < 40; i++) add_pixel(16'($urandom), i == 0);
			end else add_frame(w, 64 / w + 1);
			if (ph == 7) quiet = 1'b1;
			drain();
		end

		$display("covered %0d pixels, %0d gradient words checked, widths 2..max",
			pixels_sent, words_checked);
		if (mismatches == 0 && gradient_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
